@@ hw/rtl/lpq_pkg.sv @@
`default_nettype none

package lpq_pkg;

	localparam int DEPTH_DEF = 4096;

	// length header: two bytes, low byte first
	localparam int HDR_BYTES = 2;

	localparam logic [1:0] OP_PUSH = 2'd0;

	localparam logic [2:0] ST_PUSHED  = 3'd0;
	localparam logic [2:0] ST_DROPPED = 3'd1;
	localparam logic [2:0] ST_POPPED  = 3'd2;
	localparam logic [2:0] ST_NOPKT   = 3'd3;
	localparam logic [2:0] ST_RESET   = 3'd4;
	localparam logic [2:0] ST_BADHDR  = 3'd5;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_byte;
		logic        last_byte;
		logic [12:0] free_space;
		logic        packet_ready;
	} out_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpq_ram.sv @@
`default_nettype none

module lpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/length_prefixed_packet_ring_queue.sv @@
`default_nettype none

// channel   direction  handshake                  payload
// in        input      in_valid / in_ready        in_data  (operation, data_byte)
// out       output     out_valid / out_ready      out_data (status, out_byte, last_byte,
//                                                           free_space, packet_ready)
//
// One item at a time. Reset goes straight to the output; a push passes the check state;
// a pop inside a packet reads its byte, then checks; a pop that opens a packet first
// fetches the header. Whenever packet_ready has to look at the header at the read
// position, the single read port of the ring memory fetches its two bytes one by one.
// arst_n clears positions, count and packet state at once; the ring contents have no reset.
// A result waiting in the output register does not block acceptance of the next item;
// the block stalls only at the hand-off into the output register.

module length_prefixed_packet_ring_queue #(
	parameter int DEPTH = lpq_pkg::DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	input  wire lpq_pkg::in_t in_data,
	output logic         out_valid,
	input  wire          out_ready,
	output lpq_pkg::out_t out_data
);

	import lpq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 16) ? CW : 16;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POP  = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_F1   = 3'd3;
	localparam logic [2:0] S_F2   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   left_q;
	logic [7:0]    lo_q;
	logic          hdr_pop_q;
	out_t          res_q;
	out_t          out_q;
	logic          out_valid_q;

	logic [AW-1:0] rp_next;
	logic [AW-1:0] wp_next;
	logic          full;
	logic          cnt_lt_hdr;
	logic [15:0]   len;
	logic [12:0]   free_now;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign rp_next    = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
	assign wp_next    = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign full       = (cnt_q == CW'(DEPTH));
	assign cnt_lt_hdr = (cnt_q < CW'(HDR_BYTES));
	assign len        = {ram_rdata, lo_q};
	assign free_now   = 13'(CW'(DEPTH) - cnt_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		ram_we    = in_valid && in_ready && (in_data.operation == OP_PUSH) && !full;
		ram_re    = 1'b0;
		ram_raddr = rp_q;
		unique case (state_q)
			S_IDLE: ram_re = in_valid && !in_data.operation[1] &&
			                 (in_data.operation != OP_PUSH);
			S_CHK:  ram_re = (left_q == 16'd0) && !cnt_lt_hdr;
			S_F1: begin
				ram_re    = 1'b1;
				ram_raddr = rp_next;
			end
			default: ram_re = 1'b0;
		endcase
	end

	lpq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(in_data.data_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			left_q      <= '0;
			hdr_pop_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q.out_byte  <= '0;
						res_q.last_byte <= 1'b0;
						if (in_data.operation[1]) begin
							rp_q                <= '0;
							wp_q                <= '0;
							cnt_q               <= '0;
							left_q              <= '0;
							res_q.status        <= ST_RESET;
							res_q.free_space    <= 13'(DEPTH);
							res_q.packet_ready  <= 1'b0;
							state_q             <= S_OUT;
						end else if (in_data.operation == OP_PUSH) begin
							if (full) begin
								res_q.status <= ST_DROPPED;
							end else begin
								wp_q         <= wp_next;
								cnt_q        <= cnt_q + CW'(1);
								res_q.status <= ST_PUSHED;
							end
							state_q <= S_CHK;
						end else if (left_q != 16'd0) begin
							state_q <= S_POP;
						end else if (cnt_lt_hdr) begin
							res_q.status <= ST_NOPKT;
							state_q      <= S_CHK;
						end else begin
							// header low byte is on its way, it is also the first byte out
							hdr_pop_q <= 1'b1;
							state_q   <= S_F1;
						end
					end
				end
				S_POP: begin
					res_q.status    <= ST_POPPED;
					res_q.out_byte  <= ram_rdata;
					res_q.last_byte <= (left_q == 16'd1);
					rp_q            <= rp_next;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
					left_q  <= left_q - 16'd1;
					state_q <= S_CHK;
				end
				S_CHK: begin
					res_q.free_space <= free_now;
					if (left_q != 16'd0) begin
						res_q.packet_ready <= 1'b1;
						state_q            <= S_OUT;
					end else if (cnt_lt_hdr) begin
						res_q.packet_ready <= 1'b0;
						state_q            <= S_OUT;
					end else begin
						hdr_pop_q <= 1'b0;
						state_q   <= S_F1;
					end
				end
				S_F1: begin
					lo_q    <= ram_rdata;
					state_q <= S_F2;
				end
				S_F2: begin
					if (!hdr_pop_q) begin
						res_q.packet_ready <= (len >= 16'(HDR_BYTES)) &&
						                      (XW'(cnt_q) >= XW'(len));
						state_q            <= S_OUT;
					end else if (len < 16'(HDR_BYTES)) begin
						// bad header empties the queue
						rp_q         <= '0;
						wp_q         <= '0;
						cnt_q        <= '0;
						left_q       <= '0;
						res_q.status <= ST_BADHDR;
						state_q      <= S_CHK;
					end else if (XW'(cnt_q) < XW'(len)) begin
						res_q.status       <= ST_NOPKT;
						res_q.free_space   <= free_now;
						res_q.packet_ready <= 1'b0;
						state_q            <= S_OUT;
					end else begin
						res_q.status    <= ST_POPPED;
						res_q.out_byte  <= lo_q;
						res_q.last_byte <= 1'b0;
						rp_q            <= rp_next;
						cnt_q           <= cnt_q - CW'(1);
						left_q          <= len - 16'd1;
						state_q         <= S_CHK;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
